/* src/pva_pkg.sv */
// pva_pkg: shared types and constants of the polyphonic voice allocator
// no dependencies; imported by pva_pick, poly_voice_allocator and the test bench
`default_nettype none

package pva_pkg;

    localparam int NOTE_W  = 7;
    localparam int MASK_W  = 5;
    localparam int VOICE_W = 3;
    localparam int COUNT_W = 3;

    typedef logic [NOTE_W-1:0]  note_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [VOICE_W-1:0] voice_t;
    typedef logic [COUNT_W-1:0] count_t;

    // event kind codes
    localparam logic KIND_NOTE_ON  = 1'b0;
    localparam logic KIND_NOTE_OFF = 1'b1;

    // voices at or above this index are never enabled
    localparam int MAX_ENABLED = 5;

endpackage

`default_nettype wire

/* src/pva_pick.sv */
// pva_pick: voice choice for one note event (match, free, then oldest)
// depends on pva_pkg
`default_nettype none

module pva_pick #(
    parameter int VOICE_COUNT = 5
) (
    input  pva_pkg::note_t          note,
    input  logic [VOICE_COUNT-1:0]  en,
    input  logic [VOICE_COUNT-1:0]  busy,
    input  pva_pkg::note_t          voice_note [VOICE_COUNT],
    input  logic [VOICE_COUNT-1:0]  older [VOICE_COUNT],
    output logic [VOICE_COUNT-1:0]  sel,
    output logic                    found,
    output logic [VOICE_COUNT-1:0]  hit
);
    import pva_pkg::*;

    logic [VOICE_COUNT-1:0] match;
    logic [VOICE_COUNT-1:0] free;
    logic [VOICE_COUNT-1:0] cand;
    logic [VOICE_COUNT-1:0] pool;

    // busy voices holding this note, enabled or not
    always_comb begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
            hit[v] = busy[v] && (voice_note[v] == note);
        end
    end

    assign match = hit & en;
    assign free  = en & ~busy;

    // oldest enabled voice: no other enabled voice is older
    always_comb begin
        for (int i = 0; i < VOICE_COUNT; i++) begin
            cand[i] = en[i];
            for (int j = 0; j < VOICE_COUNT; j++) begin
                if (j != i && en[j] && older[j][i]) begin
                    cand[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (match != '0) begin
            pool = match;
        end else if (free != '0) begin
            pool = free;
        end else begin
            pool = cand;
        end
    end

    // lowest set bit
    assign sel   = pool & (~pool + VOICE_COUNT'(1));
    assign found = (en != '0);

endmodule

`default_nettype wire

/* src/poly_voice_allocator.sv */
// poly_voice_allocator: assigns note events to voices, steals the oldest
// each request passes the input register, then the result register; either can hold it while m_ready is low
// throughput: one request per cycle, input stalls only while a full result slot waits on m_ready
// reset: every voice free, enable mask all ones, both pipeline registers empty
// voice age is kept as a pairwise older-than matrix instead of wide start stamps
// depends on pva_pkg and pva_pick
`default_nettype none

module poly_voice_allocator #(
    parameter int VOICE_COUNT = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // note request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  pva_pkg::note_t           s_note,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output pva_pkg::voice_t          m_voice,
    output logic                     m_assigned,
    output pva_pkg::mask_t           m_released_mask,
    output pva_pkg::mask_t           m_key_mask,
    output pva_pkg::count_t          m_active_count,
    // enable mask write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  pva_pkg::mask_t           cfg_data
);
    import pva_pkg::*;

    localparam int IDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int IDXE_W = (IDX_W > VOICE_W) ? IDX_W : VOICE_W;
    localparam int EXT_W  = (VOICE_COUNT > MASK_W) ? VOICE_COUNT : MASK_W;

    // input stage
    logic                   q_valid_reg;
    logic                   q_valid_next;
    logic                   q_kind_reg;
    note_t                  q_note_reg;

    // voice state
    mask_t                  mask_reg;
    logic [VOICE_COUNT-1:0] busy_reg;
    logic [VOICE_COUNT-1:0] busy_next;
    note_t                  vnote_reg [VOICE_COUNT];
    // older_reg[j][i] set: voice j took its note before voice i
    logic [VOICE_COUNT-1:0] older_reg [VOICE_COUNT];

    // result stage
    logic                   m_valid_reg;
    logic                   m_valid_next;
    voice_t                 m_voice_reg;
    logic                   m_assigned_reg;
    mask_t                  m_released_reg;
    mask_t                  m_key_reg;
    count_t                 m_count_reg;

    logic                   s_fire;
    logic                   advance;
    logic                   cfg_fire;
    logic                   is_on;
    logic                   do_assign;

    logic [EXT_W-1:0]       mask_ext;
    logic [VOICE_COUNT-1:0] en;
    logic [VOICE_COUNT-1:0] sel;
    logic                   found;
    logic [VOICE_COUNT-1:0] hit;
    logic [VOICE_COUNT-1:0] released;
    logic [IDX_W-1:0]       sel_idx;
    logic [IDXE_W-1:0]      sel_idx_ext;
    logic [EXT_W-1:0]       busy_ext;
    logic [EXT_W-1:0]       released_ext;
    count_t                 active_cnt;

    // handshakes: the input stage moves on whenever the result slot is free or leaving
    assign advance   = q_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !q_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // only voices below index five can ever be enabled
    assign mask_ext = EXT_W'(mask_reg);
    assign en       = mask_ext[VOICE_COUNT-1:0];

    pva_pick #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_pick (
        .note       (q_note_reg),
        .en         (en),
        .busy       (busy_reg),
        .voice_note (vnote_reg),
        .older      (older_reg),
        .sel        (sel),
        .found      (found),
        .hit        (hit)
    );

    assign is_on     = (q_kind_reg == KIND_NOTE_ON);
    assign do_assign = advance && is_on && found;
    assign released  = (advance && !is_on) ? hit : '0;

    // one-hot choice to index
    always_comb begin
        sel_idx = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (sel[v]) begin
                sel_idx = sel_idx | IDX_W'(v);
            end
        end
    end
    assign sel_idx_ext = IDXE_W'(sel_idx);

    // busy (and with it the key-on bits) after this event
    always_comb begin
        busy_next = busy_reg;
        if (do_assign) begin
            busy_next = busy_reg | sel;
        end else if (advance && !is_on) begin
            busy_next = busy_reg & ~hit;
        end
    end

    // enabled voices holding a note, at most five
    always_comb begin
        active_cnt = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            active_cnt = active_cnt + count_t'(busy_next[v] && en[v]);
        end
    end

    assign busy_ext     = EXT_W'(busy_next);
    assign released_ext = EXT_W'(released);

    assign q_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : q_valid_reg);
    assign m_valid_next = advance ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            mask_reg    <= '1;
            busy_reg    <= '0;
        end else begin
            q_valid_reg <= q_valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_fire) begin
                // a new mask frees every voice; the same mask leaves all as is
                if (cfg_data != mask_reg) begin
                    busy_reg <= '0;
                end
                mask_reg <= cfg_data;
            end else begin
                busy_reg <= busy_next;
            end
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            q_kind_reg <= s_kind;
            q_note_reg <= s_note;
        end
    end

    // voice notes and age order, only meaningful while a voice is busy
    always_ff @(posedge aclk) begin
        if (do_assign) begin
            for (int c = 0; c < VOICE_COUNT; c++) begin
                if (sel[c]) begin
                    vnote_reg[c] <= q_note_reg;
                    older_reg[c] <= '0;
                end else begin
                    older_reg[c] <= older_reg[c] | sel;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_voice_reg    <= do_assign ? sel_idx_ext[VOICE_W-1:0] : '0;
            m_assigned_reg <= is_on && found;
            m_released_reg <= released_ext[MASK_W-1:0];
            m_key_reg      <= busy_ext[MASK_W-1:0];
            m_count_reg    <= active_cnt;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_voice         = m_voice_reg;
    assign m_assigned      = m_assigned_reg;
    assign m_released_mask = m_released_reg;
    assign m_key_mask      = m_key_reg;
    assign m_active_count  = m_count_reg;

endmodule

`default_nettype wire

/* tb/poly_voice_allocator_test.sv */
`timescale 1ns / 1ps
// poly_voice_allocator_test: self-checking bench for the polyphonic voice allocator
// drives note requests and enable mask writes; a scoreboard class predicts every result
// depends on pva_pkg and poly_voice_allocator

module poly_voice_allocator_test;
    import pva_pkg::*;

    localparam int VOICES        = 5;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 80;   // long receiver hold-off, enough to back up the pipe
    localparam int SETTLE_CYCLES = 4;    // pipeline is two deep, give it a little more

    // one predicted result
    typedef struct packed {
        voice_t voice;
        logic   assigned;
        mask_t  released;
        mask_t  keys;
        count_t active;
    } outcome_t;

    // voice table predictor plus the queue of results still owed by the block
    class voice_scoreboard;
        mask_t       enable_mask;
        logic        busy [VOICES];
        note_t       held_note [VOICES];
        logic [63:0] start_stamp [VOICES];
        logic [63:0] stamp_count;
        mask_t       key_bits;
        outcome_t    owed_q [$];
        int errors, results, requests, mask_writes;
        int steals, retriggers, releases, refused;

        function new();
            enable_mask = '1;
            clear_voices();
            errors = 0; results = 0; requests = 0; mask_writes = 0;
            steals = 0; retriggers = 0; releases = 0; refused = 0;
        endfunction

        function void clear_voices();
            for (int v = 0; v < VOICES; v++) begin
                busy[v] = 1'b0;
                held_note[v] = '0;
                start_stamp[v] = '0;
            end
            stamp_count = '0;
            key_bits = '0;
        endfunction

        function bit is_enabled(int v);
            return v < MAX_ENABLED && enable_mask[v];
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // a changed mask wipes the voice table, the same mask leaves it alone
        function void write_mask(mask_t m);
            mask_writes++;
            if (m != enable_mask)
                clear_voices();
            enable_mask = m;
        endfunction

        function void note_request(logic kind, note_t nn);
            outcome_t r;
            int pick;
            int n;
            r = '0;
            pick = -1;
            requests++;
            if (kind == KIND_NOTE_ON) begin
                // same note already sounding on an enabled voice
                for (int v = 0; v < VOICES; v++)
                    if (pick < 0 && is_enabled(v) && busy[v] && held_note[v] == nn)
                        pick = v;
                if (pick >= 0) begin
                    retriggers++;
                end else begin
                    // lowest free enabled voice
                    for (int v = 0; v < VOICES; v++)
                        if (pick < 0 && is_enabled(v) && !busy[v])
                            pick = v;
                    if (pick < 0) begin
                        // oldest start wins, lowest index on a tie
                        for (int v = 0; v < VOICES; v++)
                            if (is_enabled(v) && (pick < 0 || start_stamp[v] < start_stamp[pick]))
                                pick = v;
                        if (pick >= 0)
                            steals++;
                    end
                end
                if (pick >= 0) begin
                    busy[pick] = 1'b1;
                    held_note[pick] = nn;
                    stamp_count = stamp_count + 64'd1;
                    start_stamp[pick] = stamp_count;
                    key_bits[pick] = 1'b1;
                    r.voice = voice_t'(pick);
                    r.assigned = 1'b1;
                end else begin
                    refused++;
                end
            end else begin
                // note-off frees every holder, enabled or not
                for (int v = 0; v < VOICES; v++)
                    if (busy[v] && held_note[v] == nn) begin
                        busy[v] = 1'b0;
                        held_note[v] = '0;
                        start_stamp[v] = '0;
                        key_bits[v] = 1'b0;
                        r.released[v] = 1'b1;
                    end
                if (r.released != '0)
                    releases++;
            end
            n = 0;
            for (int v = 0; v < VOICES; v++)
                if (is_enabled(v) && busy[v])
                    n++;
            r.keys = key_bits;
            r.active = count_t'(n);
            owed_q.insert(owed_q.size(), r);
        endfunction

        task report(string what, int got_v, int exp_v);
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got_v, exp_v);
            errors++;
        endtask

        task check_result(voice_t voice, logic assigned, mask_t released, mask_t keys,
                          count_t active);
            outcome_t w;
            results++;
            if (owed_q.size() == 0) begin
                report("result with nothing outstanding, voice", voice, 0);
            end else begin
                w = owed_q.pop_front();
                if (voice !== w.voice)       report("voice", voice, w.voice);
                if (assigned !== w.assigned) report("assigned", assigned, w.assigned);
                if (released !== w.released) report("released_mask", released, w.released);
                if (keys !== w.keys)         report("key_mask", keys, w.keys);
                if (active !== w.active)     report("active_count", active, w.active);
            end
        endtask
    endclass

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    logic    s_kind;
    note_t   s_note;
    logic    m_valid;
    logic    m_ready;
    voice_t  m_voice;
    logic    m_assigned;
    mask_t   m_released_mask;
    mask_t   m_key_mask;
    count_t  m_active_count;
    logic    cfg_valid;
    logic    cfg_ready;
    mask_t   cfg_data;

    voice_scoreboard sb;

    // idle chances in percent per cycle for each side
    int send_idle;
    int recv_idle;
    // bumped by the stimulus, served by the receiver with one long hold-off each
    int stall_asks;

    poly_voice_allocator #(
        .VOICE_COUNT(VOICES)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_note          (s_note),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_voice         (m_voice),
        .m_assigned      (m_assigned),
        .m_released_mask (m_released_mask),
        .m_key_mask      (m_key_mask),
        .m_active_count  (m_active_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", sb.pending());
        $display("Mismatches found");
        $finish;
    end

    // accepted note request: predict its result
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_valid && s_ready)
            sb.note_request(s_kind, s_note);
    end

    // accepted result: compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready)
            sb.check_result(m_voice, m_assigned, m_released_mask, m_key_mask, m_active_count);
    end

    // accepted mask write: update the predictor's copy of the register
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && cfg_valid && cfg_ready)
            sb.write_mask(cfg_data);
    end

    // result side: random back-pressure, or a long hold-off when one is asked for
    initial begin : receiver
        int hold_left;
        int served;
        hold_left = 0;
        served = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (served != stall_asks) begin
                served = stall_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // one note request; random gap first, then hold valid until accepted
    task send_note(logic kind, note_t nn);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_note  <= nn;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering requests and wait for every owed result
    task pause_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    // mask writes only go in while the block is idle
    task write_mask(mask_t m);
        pause_sender();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        mask_t phase_masks [PHASES];
        int    base;
        logic  kind;
        note_t nn;

        sb = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = KIND_NOTE_ON;
        s_note     = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        send_idle  = 0;
        recv_idle  = 0;
        stall_asks = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: all five voices enabled out of reset
        send_note(KIND_NOTE_ON, 7'd0);      // lowest free voice
        send_note(KIND_NOTE_ON, 7'd127);    // top note number
        send_note(KIND_NOTE_ON, 7'd60);
        send_note(KIND_NOTE_ON, 7'd61);
        send_note(KIND_NOTE_ON, 7'd62);     // table now full
        send_note(KIND_NOTE_ON, 7'd60);     // retrigger of a held note
        send_note(KIND_NOTE_ON, 7'd85);     // steal the oldest voice
        send_note(KIND_NOTE_OFF, 7'd127);   // free one voice
        send_note(KIND_NOTE_OFF, 7'd99);    // nobody holds it
        send_note(KIND_NOTE_ON, 7'd42);     // refill the freed voice
        send_note(KIND_NOTE_ON, 7'd7);      // steal again
        send_note(KIND_NOTE_OFF, 7'd0);
        send_note(KIND_NOTE_OFF, 7'd85);

        // same mask again must keep the table
        write_mask(5'd31);
        send_note(KIND_NOTE_ON, 7'd60);

        // nothing enabled: note-on finds no voice
        write_mask(5'd0);
        send_note(KIND_NOTE_ON, 7'd10);
        send_note(KIND_NOTE_OFF, 7'd10);

        // single voice: once it is taken, every new note steals it
        write_mask(5'd1);
        send_note(KIND_NOTE_ON, 7'd3);
        send_note(KIND_NOTE_ON, 7'd4);
        send_note(KIND_NOTE_OFF, 7'd4);

        // sparse mask, voice 0 disabled
        write_mask(5'b10110);
        send_note(KIND_NOTE_ON, 7'd20);
        send_note(KIND_NOTE_ON, 7'd21);
        send_note(KIND_NOTE_ON, 7'd22);
        send_note(KIND_NOTE_ON, 7'd23);     // steal with a gap in the mask
        send_note(KIND_NOTE_OFF, 7'd21);

        // random phases, each under its own mask
        phase_masks = '{5'd31, 5'b10101, 5'd0, 5'd31, 5'd1, 5'b01110,
                        5'd31, 5'd16, 5'd31, 5'd31, 5'd3, 5'd31};
        phase_masks[6] = mask_t'($urandom);
        phase_masks[9] = mask_t'($urandom);

        for (int p = 0; p < PHASES; p++) begin
            // receiver lazy first, then sender lazy, then both flat out
            if (p < 4) begin
                send_idle = 18;
                recv_idle = 49;
            end else if (p < 8) begin
                send_idle = 49;
                recv_idle = 18;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_mask(phase_masks[p]);
            // a narrow note window keeps retriggers and releases frequent
            base = $urandom_range(120);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 30 && (p == 1 || p == 5 || p == 9))
                    stall_asks++;
                if (i == 60 && p == 6)
                    pause_sender();
                kind = ($urandom_range(99) < 40) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                if ($urandom_range(3) == 0)
                    nn = note_t'($urandom_range(127));
                else
                    nn = note_t'(base + $urandom_range(7));
                send_note(kind, nn);
            end
        end

        // drain and let the pipe go quiet
        pause_sender();
        repeat (10) @(posedge aclk);

        $display("ran %0d note requests under %0d mask writes, %0d results checked",
                 sb.requests, sb.mask_writes, sb.results);
        $display("saw %0d steals, %0d retriggers, %0d releases, %0d refused note-ons",
                 sb.steals, sb.retriggers, sb.releases, sb.refused);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* poly_voice_allocator.f */
src/pva_pkg.sv
src/pva_pick.sv
src/poly_voice_allocator.sv
tb/poly_voice_allocator_test.sv
